>>> hdl/ctf_pkg.sv
`timescale 1ns / 1ps

package ctf_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_len;
    typedef logic [3:0]  t_pos;

    // Link write size in bytes, including the three bytes of link overhead.
    localparam int PACKET_SIZE   = 23;
    localparam int LINK_OVERHEAD = 3;
    localparam int FIRST_HDR_LEN = 11;
    localparam int NEXT_HDR_LEN  = 5;

    // Payload bytes that fit in the first and in a later packet.
    localparam t_byte MAX_FIRST = t_byte'(PACKET_SIZE - LINK_OVERHEAD - FIRST_HDR_LEN);
    localparam t_byte MAX_NEXT  = t_byte'(PACKET_SIZE - LINK_OVERHEAD - NEXT_HDR_LEN);

    localparam t_byte TRANSFER_TYPE_RESET = 8'h82;
    localparam t_byte HDR_START  = 8'h03;
    localparam t_byte FLAG_FIRST = 8'h01;
    localparam t_byte FLAG_LAST  = 8'h06;
    localparam t_byte BYTE_ZERO  = 8'h00;

    // Output sequence positions of one request. A later packet header uses
    // positions 0 to 4 and then jumps to the payload position.
    localparam t_pos POS_START    = 4'd0;
    localparam t_pos POS_FLAGS    = 4'd1;
    localparam t_pos POS_PAD      = 4'd2;
    localparam t_pos POS_HANDLE   = 4'd3;
    localparam t_pos POS_COUNT    = 4'd4;
    localparam t_pos POS_LEN_LO   = 4'd5;
    localparam t_pos POS_LEN_HI   = 4'd6;
    localparam t_pos POS_LEN_B2   = 4'd7;
    localparam t_pos POS_LEN_B3   = 4'd8;
    localparam t_pos POS_TYPE_LO  = 4'd9;
    localparam t_pos POS_TYPE_HI  = 4'd10;
    localparam t_pos POS_PAYLOAD  = t_pos'(FIRST_HDR_LEN);
    localparam t_pos POS_NEXT_END = t_pos'(NEXT_HDR_LEN - 1);

endpackage

>>> hdl/chunked_transfer_framer_unit.sv
`timescale 1ns / 1ps

// Channel   | Handshake          | Payload
// ----------+--------------------+------------------------------------------------
// input     | i_valid / o_ready  | i_payload_byte, i_first_of_message,
//           |                    | i_message_length, i_handle
// output    | o_valid / i_ready  | o_out_byte, o_end_of_packet, o_end_of_message
// config    | i_cfg_we           | i_cfg_data (transfer type)
//
// Each accepted request updates the framing state in the cycle it is taken and
// lands in a work register; a byte sequencer then feeds the output register one
// byte per cycle while the output is not stalled. A payload-only request sends
// its payload byte alone, one opening a later packet the five-byte header first,
// one opening a message the eleven-byte header first; a dropped request, none.
// Reset (i_rst_n low, synchronous) closes any message and empties both stages.
// A stall on the output holds the output register and, behind it, the work
// register; the input is taken again as soon as the last byte of the work
// register moves on.

module chunked_transfer_framer_unit
    import ctf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_first_of_message,
    input  logic [15:0] i_message_length,
    input  logic [7:0]  i_handle,

    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_end_of_packet,
    output logic        o_end_of_message,

    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data
);

    // Framing state
    t_byte r_transfer_type;
    t_len  r_remaining, n_remaining;
    t_byte r_count,     n_count;
    t_byte r_room,      n_room;
    t_byte r_handle,    n_handle;

    // Work register: one request waiting to be serialised
    logic  r_w_valid;
    t_pos  r_w_pos,   n_w_pos_start;
    logic  r_w_first, n_w_first;
    t_byte r_w_flags, n_w_flags;
    t_len  r_w_len;
    t_byte r_w_data;
    logic  r_w_eop,   n_w_eop;
    logic  r_w_eom,   n_w_eom;
    logic  n_w_load;

    // Output register
    logic  r_o_valid;
    t_byte r_o_byte;
    logic  r_o_eop;
    logic  r_o_eom;

    logic  accept;
    logic  emit;
    logic  w_done;
    t_pos  pos_next;
    t_byte emit_byte;
    t_byte room_fit;
    t_len  rem_base;

    // Load the output register from a held request whenever it is empty or being drained
    assign emit    = r_w_valid && (!r_o_valid || i_ready);
    assign w_done  = emit && (r_w_pos == POS_PAYLOAD);
    assign o_ready = !r_w_valid || w_done;
    assign accept  = i_valid && o_ready;

    // Framing decision for the offered request
    always_comb begin
        n_remaining   = r_remaining;
        n_count       = r_count;
        n_room        = r_room;
        n_handle      = r_handle;
        n_w_load      = 1'b0;
        n_w_first     = 1'b0;
        n_w_pos_start = POS_PAYLOAD;
        n_w_flags     = BYTE_ZERO;
        n_w_eop       = 1'b0;
        n_w_eom       = 1'b0;
        rem_base      = r_remaining;
        room_fit      = r_room;

        if (i_first_of_message) begin
            if (i_message_length == '0) begin
                // Empty message: close whatever was open, emit nothing
                n_remaining = '0;
                n_room      = '0;
            end else begin
                rem_base      = i_message_length;
                n_handle      = i_handle;
                n_count       = '0;
                n_w_load      = 1'b1;
                n_w_first     = 1'b1;
                n_w_pos_start = POS_START;
                n_w_flags     = (i_message_length <= t_len'(MAX_FIRST))
                              ? (FLAG_FIRST | FLAG_LAST) : FLAG_FIRST;
                room_fit      = (i_message_length < t_len'(MAX_FIRST))
                              ? i_message_length[7:0] : MAX_FIRST;
            end
        end else if (r_remaining != '0) begin
            n_w_load = 1'b1;
            if (r_room == '0) begin
                // Open a later packet
                n_count       = r_count + 8'd1;
                n_w_pos_start = POS_START;
                n_w_flags     = (r_remaining <= t_len'(MAX_NEXT)) ? FLAG_LAST : BYTE_ZERO;
                room_fit      = (r_remaining < t_len'(MAX_NEXT))
                              ? r_remaining[7:0] : MAX_NEXT;
            end
        end

        if (n_w_load) begin
            n_room      = room_fit - 8'd1;
            n_remaining = rem_base - 16'd1;
            n_w_eop     = (n_room == '0);
            n_w_eom     = (n_remaining == '0);
        end
    end

    // Sequencer: a later packet header skips the first-packet extension
    always_comb begin
        if (r_w_pos == POS_NEXT_END && !r_w_first) begin
            pos_next = POS_PAYLOAD;
        end else begin
            pos_next = r_w_pos + 4'd1;
        end
    end

    always_comb begin
        case (r_w_pos)
            POS_START:   emit_byte = HDR_START;
            POS_FLAGS:   emit_byte = r_w_flags;
            POS_PAD:     emit_byte = BYTE_ZERO;
            POS_HANDLE:  emit_byte = r_handle;
            POS_COUNT:   emit_byte = r_count;
            POS_LEN_LO:  emit_byte = r_w_len[7:0];
            POS_LEN_HI:  emit_byte = r_w_len[15:8];
            POS_LEN_B2:  emit_byte = BYTE_ZERO;
            POS_LEN_B3:  emit_byte = BYTE_ZERO;
            POS_TYPE_LO: emit_byte = r_transfer_type;
            POS_TYPE_HI: emit_byte = BYTE_ZERO;
            POS_PAYLOAD: emit_byte = r_w_data;
            default:     emit_byte = BYTE_ZERO;
        endcase
    end

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transfer_type <= TRANSFER_TYPE_RESET;
        end else if (i_cfg_we) begin
            r_transfer_type <= i_cfg_data;
        end
    end

    // Framing state advances on every accepted request, dropped ones included.
    // Handle and count are read by the sequencer only while the work register
    // holds a request, and that request blocks any further update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_count     <= '0;
            r_room      <= '0;
            r_handle    <= '0;
        end else if (accept) begin
            r_remaining <= n_remaining;
            r_count     <= n_count;
            r_room      <= n_room;
            r_handle    <= n_handle;
        end
    end

    // Work register control: empty it once its payload byte moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
            r_w_pos   <= POS_PAYLOAD;
        end else if (accept) begin
            r_w_valid <= n_w_load;
            r_w_pos   <= n_w_pos_start;
        end else if (emit) begin
            r_w_valid <= !w_done;
            r_w_pos   <= pos_next;
        end
    end

    // Work register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_w_first <= n_w_first;
            r_w_flags <= n_w_flags;
            r_w_len   <= i_message_length;
            r_w_data  <= i_payload_byte;
            r_w_eop   <= n_w_eop;
            r_w_eom   <= n_w_eom;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (emit) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_byte <= emit_byte;
            r_o_eop  <= (r_w_pos == POS_PAYLOAD) && r_w_eop;
            r_o_eom  <= (r_w_pos == POS_PAYLOAD) && r_w_eom;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_out_byte       = r_o_byte;
    assign o_end_of_packet  = r_o_eop;
    assign o_end_of_message = r_o_eom;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb
    import ctf_pkg::*;
();

    localparam int  HALF_PERIOD  = 4;
    // Cycles to let pass once the last byte is out, so the block is quiet before
    // the transfer type changes.
    localparam int  SETTLE_TICKS = 16;
    // Upper bound on the run time in nanoseconds; a run that reaches it fails.
    localparam int  RUN_LIMIT_NS = 5_000_000;

    // One framed byte as it should appear on the output port.
    typedef struct packed {
        t_byte value;
        logic  eop;
        logic  eom;
    } framed_byte_t;

    // Tracks the framing state and holds the byte stream still owed by the block.
    class framer_tracker;
        t_byte        xfer_type;
        t_len         remaining;
        t_byte        pkt_count;
        t_byte        room;
        t_byte        handle;
        framed_byte_t owed_bytes[$];
        int           mismatches;

        function new();
            xfer_type  = TRANSFER_TYPE_RESET;
            remaining  = '0;
            pkt_count  = '0;
            room       = '0;
            handle     = '0;
            mismatches = 0;
        endfunction

        function void owe(t_byte value, logic eop = 1'b0, logic eom = 1'b0);
            framed_byte_t fb;
            fb.value = value;
            fb.eop   = eop;
            fb.eom   = eom;
            owed_bytes.push_back(fb);
        endfunction

        function void owe_link_header(t_byte flags);
            owe(HDR_START);
            owe(flags);
            owe(BYTE_ZERO);
            owe(handle);
            owe(pkt_count);
        endfunction

        // Note one accepted request and work out the bytes it causes.
        function void take_request(t_byte data, logic first, t_len len, t_byte hnd);
            t_byte flags;
            if (first) begin
                if (len == '0) begin
                    remaining = '0;
                    room      = '0;
                    return;
                end
                remaining = len;
                handle    = hnd;
                pkt_count = '0;
                flags     = FLAG_FIRST | ((len <= MAX_FIRST) ? FLAG_LAST : BYTE_ZERO);
                owe_link_header(flags);
                owe(len[7:0]);
                owe(len[15:8]);
                owe(BYTE_ZERO);
                owe(BYTE_ZERO);
                owe(xfer_type);
                owe(BYTE_ZERO);
                room = (remaining < MAX_FIRST) ? remaining[7:0] : MAX_FIRST;
            end else begin
                if (remaining == '0) begin
                    return;
                end
                if (room == '0) begin
                    flags     = (remaining <= MAX_NEXT) ? FLAG_LAST : BYTE_ZERO;
                    pkt_count = pkt_count + 8'd1;
                    owe_link_header(flags);
                    room = (remaining < MAX_NEXT) ? remaining[7:0] : MAX_NEXT;
                end
            end
            room      = room - 8'd1;
            remaining = remaining - 16'd1;
            owe(data, room == '0, remaining == '0);
        endfunction

        // Compare one output byte against the oldest owed byte.
        function void check_byte(t_byte value, logic eop, logic eom);
            framed_byte_t fb;
            if (owed_bytes.size() == 0) begin
                $display("%0t: byte %02h with nothing owed", $time, value);
                mismatches++;
                return;
            end
            fb = owed_bytes.pop_front();
            if (value !== fb.value) begin
                $display("%0t: out_byte expected %02h actual %02h", $time, fb.value, value);
                mismatches++;
            end
            if (eop !== fb.eop) begin
                $display("%0t: end_of_packet expected %0b actual %0b", $time, fb.eop, eop);
                mismatches++;
            end
            if (eom !== fb.eom) begin
                $display("%0t: end_of_message expected %0b actual %0b", $time, fb.eom, eom);
                mismatches++;
            end
        endfunction

        function int owed();
            return owed_bytes.size();
        endfunction
    endclass

    logic        i_clk              = 1'b0;
    logic        i_rst_n            = 1'b0;
    logic        i_valid            = 1'b0;
    logic        o_ready;
    logic [7:0]  i_payload_byte     = '0;
    logic        i_first_of_message = 1'b0;
    logic [15:0] i_message_length   = '0;
    logic [7:0]  i_handle           = '0;
    logic        o_valid;
    logic        i_ready            = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_end_of_packet;
    logic        o_end_of_message;
    logic        i_cfg_we           = 1'b0;
    logic [7:0]  i_cfg_data         = '0;

    framer_tracker sb;

    // Idling control for the sender and the receiver.
    bit calm        = 1'b0;  // no gaps on either side while set
    int hold_ask    = 0;     // long receiver hold-off, picked up by the receiver
    int hold_left   = 0;
    int stall_left  = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    chunked_transfer_framer_unit u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_payload_byte     (i_payload_byte),
        .i_first_of_message (i_first_of_message),
        .i_message_length   (i_message_length),
        .i_handle           (i_handle),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_out_byte         (o_out_byte),
        .o_end_of_packet    (o_end_of_packet),
        .o_end_of_message   (o_end_of_message),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data)
    );

    // Mostly back-to-back requests, some short gaps, the odd long one.
    function automatic int sender_gap();
        int pick;
        pick = $urandom_range(0, 9);
        if (calm || pick < 6) begin
            return 0;
        end
        return (pick < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    function automatic int receiver_stall();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 20);
    endfunction

    // Receiver: check every byte taken, then pick ready for the next edge.
    // Sample before the edge's updates land, so no check races the block.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_byte(o_out_byte, o_end_of_packet, o_end_of_message);
        end
        if (hold_ask > 0) begin
            hold_left = hold_ask;
            hold_ask  = 0;
        end
        if (hold_left > 0) begin
            // Hold off for the whole stretch so the block backs up into its input.
            hold_left--;
            i_ready <= 1'b0;
        end else if (calm) begin
            i_ready <= 1'b1;
        end else begin
            if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
                stall_left = receiver_stall();
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Offer one request and hold it until taken. Valid is only lowered ahead of
    // a gap, so a request that follows at once keeps valid high without a glitch.
    task automatic send_request(t_byte data, logic first, t_len len, t_byte hnd);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_payload_byte     <= data;
        i_first_of_message <= first;
        i_message_length   <= len;
        i_handle           <= hnd;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.take_request(data, first, len, hnd);
    endtask

    // Open a message of the given length and send n_items bytes of it. Fewer
    // bytes leave it open; more run past its end and get dropped. Later bytes
    // carry noise in the length and handle fields, which the block must ignore.
    task automatic send_message(t_len len, t_byte hnd, int n_items);
        for (int k = 0; k < n_items; k++) begin
            if (k == 0) begin
                send_request(t_byte'($urandom), 1'b1, len, hnd);
            end else begin
                send_request(t_byte'($urandom), 1'b0, t_len'($urandom), t_byte'($urandom));
            end
        end
    endtask

    // Drop valid and wait for every owed byte, then let the block settle.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.owed() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    // Change the transfer type only with the block idle.
    task automatic write_transfer_type(t_byte value);
        wait_idle();
        i_cfg_data <= value;
        i_cfg_we   <= 1'b1;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        sb.xfer_type  = value;
    endtask

    function automatic t_len short_length();
        return ($urandom_range(0, 9) == 0) ? t_len'($urandom_range(25, 80))
                                           : t_len'($urandom_range(1, 24));
    endfunction

    initial begin
        int   offered;
        int   stage;
        int   pick;
        t_len len;

        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, transfer type still at its reset value.
        // Byte with no message open: drop it.
        send_request(8'hA5, 1'b0, 16'hFFFF, 8'hFF);
        // One-byte message: first and last flags together.
        send_request(8'h00, 1'b1, 16'd1, 8'hFF);
        // Exactly fills the first packet, then a message one byte longer spilling into a second.
        send_message(t_len'(MAX_FIRST), 8'h00, MAX_FIRST);
        send_message(t_len'(MAX_FIRST) + 16'd1, 8'h3C, MAX_FIRST + 1);
        // Longest length, abandoned by a new message while still open.
        send_request(8'hFF, 1'b1, 16'hFFFF, 8'h5A);
        send_request(8'h81, 1'b0, 16'h0000, 8'h00);
        send_request(8'h7E, 1'b1, 16'd3, 8'hC3);
        // Zero length closes the open message; the next byte has nowhere to go.
        send_request(8'h42, 1'b1, 16'd0, 8'h99);
        send_request(8'h24, 1'b0, 16'd5, 8'h11);

        // Transfer type at both extremes.
        write_transfer_type(8'h00);
        send_message(16'd12, 8'h81, 12);
        write_transfer_type(8'hFF);
        send_message(16'd5, 8'h18, 5);

        // Random part: mostly whole messages, plus cut-offs, overruns, zero
        // lengths and stray bytes.
        offered = 0;
        stage   = 0;
        while (offered < 200) begin
            calm = ($urandom_range(0, 9) == 0);
            if (stage == 0 && offered >= 60) begin
                write_transfer_type(t_byte'($urandom));
                stage = 1;
            end
            if (stage == 1 && offered >= 120) begin
                // Hold the receiver off while a long message keeps coming, so the
                // block fills and stalls its input; then pause until drained.
                calm     = 1'b0;
                hold_ask = 300;
                send_message(16'd60, t_byte'($urandom), 60);
                offered += 60;
                wait_idle();
                stage = 2;
            end
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                len = short_length();
                send_message(len, t_byte'($urandom), len);
                offered += len;
            end else if (pick < 80) begin
                pick = $urandom_range(1, 12);
                send_message(t_len'($urandom_range(1, 65535)), t_byte'($urandom), pick);
                offered += pick;
            end else if (pick < 87) begin
                send_request(t_byte'($urandom), 1'b1, 16'd0, t_byte'($urandom));
            end else if (pick < 95) begin
                repeat ($urandom_range(1, 3)) begin
                    send_request(t_byte'($urandom), 1'b0, t_len'($urandom),
                                 t_byte'($urandom));
                end
            end else begin
                len = short_length();
                send_message(len, t_byte'($urandom), len + $urandom_range(1, 3));
                offered += len;
            end
        end
        calm = 1'b0;

        // Back to the reset transfer type for a last message.
        write_transfer_type(TRANSFER_TYPE_RESET);
        send_message(16'd30, 8'hE7, 30);

        wait_idle();
        if (sb.mismatches == 0 && sb.owed() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
